// ===== hw/rtl/qeic_pkg.sv =====
// Package for the quadrature encoder interval counter.
// Holds the step codes, the item layout and the fixed field widths.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qeic_pkg;

    // What an input item asks for.
    typedef enum logic [1:0] {
        ACT_EDGE_A = 2'd0,
        ACT_EDGE_B = 2'd1,
        ACT_LATCH  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Fixed widths of the stream fields.
    localparam int CHANNEL_W  = 2;
    localparam int REPORT_W   = 16;
    localparam int REPORTED   = 4;
    localparam int MASK_W     = 4;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_FIELDS_W = REPORTED * REPORT_W + REPORTED + REPORT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Reset value of the invert mask: channels two and three reversed.
    localparam logic [MASK_W-1:0] INVERT_RESET = 4'd12;

    // One input item as it travels from the input register to the core.
    typedef struct packed {
        t_action              action;
        logic [CHANNEL_W-1:0] channel;
        logic                 other_phase_level;
    } t_item;

endpackage

`default_nettype wire

// ===== hw/rtl/qeic_in_reg.sv =====
// Input register of the quadrature encoder interval counter.
// Captures one item from the slave stream and holds it until the core takes it.
// Depends on qeic_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module qeic_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  qeic_pkg::t_item    i_item,
    output logic               o_valid,
    output qeic_pkg::t_item    o_item,
    input  wire logic          i_take
);

    logic            r_valid;
    qeic_pkg::t_item r_item;

    // The register is free when empty or when its item leaves this cycle.
    assign o_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/qeic_count_core.sv =====
// Counting core of the quadrature encoder interval counter.
// Holds running and latched counts, applies one item per cycle unless the result stalls, and registers the result.
// Depends on qeic_pkg for codes, widths and the item type.
`timescale 1ns / 1ps
`default_nettype none

module qeic_count_core #(
    parameter int CHANNELS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  qeic_pkg::t_item                    i_item,
    output logic                               o_take,
    input  wire logic [qeic_pkg::MASK_W-1:0]   i_invert_mask,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [qeic_pkg::M_TDATA_W-1:0]     o_data
);

    localparam int DIR_N = (CHANNELS < qeic_pkg::REPORTED) ? CHANNELS : qeic_pkg::REPORTED;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam int PAD_W = qeic_pkg::M_TDATA_W - qeic_pkg::M_FIELDS_W;

    logic signed [COUNT_WIDTH-1:0] r_run [CHANNELS];
    logic signed [COUNT_WIDTH-1:0] n_run [CHANNELS];
    logic signed [COUNT_WIDTH-1:0] r_lat [CHANNELS];
    logic signed [COUNT_WIDTH-1:0] n_lat [CHANNELS];
    logic [qeic_pkg::REPORTED-1:0] r_dir;
    logic [qeic_pkg::REPORTED-1:0] n_dir;

    logic                              r_out_valid;
    logic [qeic_pkg::M_TDATA_W-1:0]    r_out_data;
    logic [qeic_pkg::M_TDATA_W-1:0]    n_out_data;

    logic                              count_up;
    logic [qeic_pkg::REPORT_W-1:0]     lat_field [qeic_pkg::REPORTED];
    logic [qeic_pkg::REPORT_W-1:0]     run_field;

    // Keep the low report bits of a count, sign-extended when the count is narrower.
    function automatic logic [qeic_pkg::REPORT_W-1:0] to_report(
        input logic signed [COUNT_WIDTH-1:0] v
    );
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[qeic_pkg::REPORT_W-1:0];
    endfunction

    // An item moves on when the result register is free or being emptied.
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // Direction of one edge: A counts up with the other phase high, B the reverse.
    always_comb begin
        count_up = (i_item.action == qeic_pkg::ACT_EDGE_A) ? i_item.other_phase_level
                                                           : !i_item.other_phase_level;
        count_up = count_up ^ i_invert_mask[i_item.channel];
    end

    // Next state of the counters for the item in the input register.
    always_comb begin
        n_run = r_run;
        n_lat = r_lat;
        n_dir = r_dir;
        case (i_item.action)
            qeic_pkg::ACT_EDGE_A, qeic_pkg::ACT_EDGE_B: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (int'(i_item.channel) == k) begin
                        if (count_up) begin
                            if (r_run[k] != CNT_MAX) begin
                                n_run[k] = r_run[k] + COUNT_WIDTH'(1);
                            end
                        end else begin
                            if (r_run[k] != CNT_MIN) begin
                                n_run[k] = r_run[k] - COUNT_WIDTH'(1);
                            end
                        end
                    end
                end
            end
            qeic_pkg::ACT_LATCH: begin
                n_dir = '0;
                for (int k = 0; k < CHANNELS; k++) begin
                    n_lat[k] = r_run[k];
                    n_run[k] = '0;
                end
                for (int k = 0; k < DIR_N; k++) begin
                    n_dir[k] = r_run[k][COUNT_WIDTH-1];
                end
            end
            default: begin
            end
        endcase
    end

    // Latched count fields; channels that do not exist report zero.
    for (genvar g = 0; g < qeic_pkg::REPORTED; g++) begin : g_lat_field
        if (g < CHANNELS) begin : g_live
            assign lat_field[g] = to_report(n_lat[g]);
        end else begin : g_absent
            assign lat_field[g] = '0;
        end
    end

    // Running count of the addressed channel after this item.
    always_comb begin
        run_field = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (int'(i_item.channel) == k) begin
                run_field = to_report(n_run[k]);
            end
        end
    end

    // Result layout, highest bits first.
    assign n_out_data = {{PAD_W{1'b0}}, run_field, n_dir,
                         lat_field[3], lat_field[2], lat_field[1], lat_field[0]};

    // Counter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_run[k] <= '0;
                r_lat[k] <= '0;
            end
            r_dir <= '0;
        end else if (o_take) begin
            r_run <= n_run;
            r_lat <= n_lat;
            r_dir <= n_dir;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Direction flags always follow the sign of the latched counts.
    for (genvar g = 0; g < DIR_N; g++) begin : g_dir_check
        a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_dir[g] == r_lat[g][COUNT_WIDTH-1])
            else $error("direction flag disagrees with latched count sign");
    end

    // A latch step leaves the running count of channel zero at zero.
    a_latch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.action == qeic_pkg::ACT_LATCH) |=> (r_run[0] == '0))
        else $error("running count not cleared by latch");

    // Only a latch step may change the latched count of channel zero.
    a_lat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(o_take && i_item.action == qeic_pkg::ACT_LATCH)) |=> $stable(r_lat[0]))
        else $error("latched count changed without a latch step");

    // A result is never overwritten while it waits to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_take)
        else $error("item taken while result register is stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/quad_encoder_interval_counter.sv =====
// Quadrature encoder interval counter, top level.
// Input stream (i_s_*): one item per handshake. tuser carries the action
// (edge on phase A, edge on phase B, period-end latch, no-op); tdata carries
// the channel and the sampled level of the opposite phase.
// Output stream (o_m_*): one result item per input item, in order: the four
// latched counts, the direction bits and the addressed channel's running count.
// Configuration: i_cfg_wr_en writes the invert mask (one bit per channel) at
// the clock edge; it resets to channels two and three reversed.
// Each item passes the input register, then the result register. Throughput:
// one item per cycle while the receiver takes results; a single add-or-subtract
// with saturation lies between the two registers.
// Reset (synchronous, active low) clears all counts, the direction bits and
// both pipeline registers. When the receiver stalls, the result register holds
// its item and the input register still takes one more item; after that
// o_s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module quad_encoder_interval_counter #(
    parameter int CHANNELS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Slave stream.
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: [1:0] channel, [2] other_phase_level, [7:3] zero.
    input  wire logic [qeic_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: [1:0] action.
    input  wire logic [qeic_pkg::S_TUSER_W-1:0]      i_s_tuser,
    // Master stream.
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: [15:0] latched_count_0, [31:16] latched_count_1,
    // [47:32] latched_count_2, [63:48] latched_count_3,
    // [67:64] direction_bits, [83:68] running_count, [87:84] zero.
    output logic [qeic_pkg::M_TDATA_W-1:0]           o_m_tdata,
    // Configuration.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [qeic_pkg::MASK_W-1:0]         i_cfg_wr_data
);

    logic [qeic_pkg::MASK_W-1:0] r_invert_mask;
    qeic_pkg::t_item             s_item;
    qeic_pkg::t_item             held_item;
    logic                        held_valid;
    logic                        take;

    // Invert mask register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_mask <= qeic_pkg::INVERT_RESET;
        end else if (i_cfg_wr_en) begin
            r_invert_mask <= i_cfg_wr_data;
        end
    end

    // Unpack the slave stream fields.
    always_comb begin
        s_item.action            = qeic_pkg::t_action'(i_s_tuser);
        s_item.channel           = i_s_tdata[qeic_pkg::CHANNEL_W-1:0];
        s_item.other_phase_level = i_s_tdata[qeic_pkg::CHANNEL_W];
    end

    qeic_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    qeic_count_core #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (held_valid),
        .i_item        (held_item),
        .o_take        (take),
        .i_invert_mask (r_invert_mask),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_data        (o_m_tdata)
    );

endmodule

`default_nettype wire
